// File: hw/rtl/sit_pkg.sv
// Shared types for the segment intersection test pipeline.
// No dependencies; imported by every stage module and the top level.
package sit_pkg;

  // Control tag that travels alongside each item through the pipeline.
  typedef struct packed {
    logic valid;
    logic reject;
  } sit_tag_t;

  localparam logic FALSE = 1'b0;

endpackage

// File: hw/rtl/sit_front.sv
// Front stage: endpoint differences and the bounding-box reject test.
// Depends on sit_pkg.
module sit_front import sit_pkg::*; #(
  parameter int CB = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic signed [CB-1:0] ax0,
  input  logic signed [CB-1:0] ay0,
  input  logic signed [CB-1:0] ax1,
  input  logic signed [CB-1:0] ay1,
  input  logic signed [CB-1:0] bx0,
  input  logic signed [CB-1:0] by0,
  input  logic signed [CB-1:0] bx1,
  input  logic signed [CB-1:0] by1,
  output sit_tag_t             tag,
  output logic signed [CB:0]   dax,
  output logic signed [CB:0]   day,
  output logic signed [CB:0]   dbx,
  output logic signed [CB:0]   dby,
  output logic signed [CB:0]   ex,
  output logic signed [CB:0]   ey
);

  logic reject_x;
  logic reject_y;

  // Both endpoints of A strictly beyond both endpoints of B on one side.
  assign reject_x = (ax0 > bx0 && ax0 > bx1 && ax1 > bx0 && ax1 > bx1) ||
                    (ax0 < bx0 && ax0 < bx1 && ax1 < bx0 && ax1 < bx1);
  assign reject_y = (ay0 > by0 && ay0 > by1 && ay1 > by0 && ay1 > by1) ||
                    (ay0 < by0 && ay0 < by1 && ay1 < by0 && ay1 < by1);

  always_ff @(posedge clk) begin
    if (rst) begin
      tag.valid <= 1'b0;
    end else begin
      tag.valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    tag.reject <= reject_x | reject_y;
    dax        <= (CB+1)'(ax1) - (CB+1)'(ax0);
    day        <= (CB+1)'(ay1) - (CB+1)'(ay0);
    dbx        <= (CB+1)'(bx1) - (CB+1)'(bx0);
    dby        <= (CB+1)'(by1) - (CB+1)'(by0);
    ex         <= (CB+1)'(bx0) - (CB+1)'(ax0);
    ey         <= (CB+1)'(by0) - (CB+1)'(ay0);
  end

endmodule

// File: hw/rtl/sit_mult.sv
// Multiply stage: the six partial products of the three cross products.
// Depends on sit_pkg.
module sit_mult import sit_pkg::*; #(
  parameter int CB = 16,
  localparam int PW = 2*CB + 2
) (
  input  logic                 clk,
  input  logic                 rst,
  input  sit_tag_t             tag_in,
  input  logic signed [CB:0]   dax,
  input  logic signed [CB:0]   day,
  input  logic signed [CB:0]   dbx,
  input  logic signed [CB:0]   dby,
  input  logic signed [CB:0]   ex,
  input  logic signed [CB:0]   ey,
  output sit_tag_t             tag,
  output logic signed [PW-1:0] p_den0,
  output logic signed [PW-1:0] p_den1,
  output logic signed [PW-1:0] p_na0,
  output logic signed [PW-1:0] p_na1,
  output logic signed [PW-1:0] p_nb0,
  output logic signed [PW-1:0] p_nb1
);

  always_ff @(posedge clk) begin
    if (rst) begin
      tag.valid <= 1'b0;
    end else begin
      tag.valid <= tag_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    tag.reject <= tag_in.reject;
    p_den0     <= dbx * day;
    p_den1     <= dax * dby;
    p_na0      <= dbx * ey;
    p_na1      <= dby * ex;
    p_nb0      <= dax * ey;
    p_nb1      <= day * ex;
  end

endmodule

// File: hw/rtl/sit_judge.sv
// Decision stages: form the cross products, then test both positions
// against the closed range 0 to 1 by sign and magnitude. Depends on sit_pkg.
module sit_judge import sit_pkg::*; #(
  parameter int CB = 16,
  localparam int PW = 2*CB + 2,
  localparam int XW = PW + 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  sit_tag_t             tag_in,
  input  logic signed [PW-1:0] p_den0,
  input  logic signed [PW-1:0] p_den1,
  input  logic signed [PW-1:0] p_na0,
  input  logic signed [PW-1:0] p_na1,
  input  logic signed [PW-1:0] p_nb0,
  input  logic signed [PW-1:0] p_nb1,
  output logic                 done,
  output logic                 hit
);

  sit_tag_t             tag_x;
  logic signed [XW-1:0] den;
  logic signed [XW-1:0] na;
  logic signed [XW-1:0] nb;
  logic                 na_in;
  logic                 nb_in;

  function automatic logic in_unit(input logic signed [XW-1:0] n,
                                   input logic signed [XW-1:0] d);
    if (d > 0) begin
      return n >= 0 && n <= d;
    end
    return n <= 0 && n >= d;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_x.valid <= 1'b0;
      done        <= 1'b0;
    end else begin
      tag_x.valid <= tag_in.valid;
      done        <= tag_x.valid;
    end
  end

  always_ff @(posedge clk) begin
    tag_x.reject <= tag_in.reject;
    den          <= XW'(p_den0) - XW'(p_den1);
    na           <= XW'(p_na0) - XW'(p_na1);
    nb           <= XW'(p_nb0) - XW'(p_nb1);
  end

  assign na_in = in_unit(na, den);
  assign nb_in = in_unit(nb, den);

  // Drop rejected and parallel or degenerate pairs.
  always_ff @(posedge clk) begin
    if (tag_x.reject || den == '0) begin
      hit <= FALSE;
    end else begin
      hit <= na_in & nb_in;
    end
  end

endmodule

// File: hw/rtl/segment_intersection_test_unit.sv
// Top level of the segment intersection test pipeline.
// Depends on sit_pkg, sit_front, sit_mult and sit_judge.
//
// Usage: drive the eight coordinates of segments A and B and raise start;
// the pair is taken at that clock edge (busy is always low, so one pair can
// be taken every cycle). Coordinates are COORD_BITS wide, two's complement.
// When the pair leaves the last stage, done is high for exactly one cycle and
// hit holds the answer: 1 when the closed segments share a point. Parallel,
// collinear and single-point segments give hit = 0.
// Throughput: one pair per clock, set by the four-stage pipeline (differences
// and box reject, six products, cross products, range test).
// Reset (rst, synchronous) clears every valid bit in the pipeline, so no
// result beat appears for pairs in flight. The receiver takes every result
// beat in the cycle it is shown; there is no back-pressure.
module segment_intersection_test_unit import sit_pkg::*; #(
  parameter int COORD_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [COORD_BITS-1:0] seg_a_start_x,
  input  logic signed [COORD_BITS-1:0] seg_a_start_y,
  input  logic signed [COORD_BITS-1:0] seg_a_end_x,
  input  logic signed [COORD_BITS-1:0] seg_a_end_y,
  input  logic signed [COORD_BITS-1:0] seg_b_start_x,
  input  logic signed [COORD_BITS-1:0] seg_b_start_y,
  input  logic signed [COORD_BITS-1:0] seg_b_end_x,
  input  logic signed [COORD_BITS-1:0] seg_b_end_y,
  output logic                         done,
  output logic                         hit
);

  localparam int PW = 2*COORD_BITS + 2;

  sit_tag_t                     tag_f;
  sit_tag_t                     tag_m;
  logic signed [COORD_BITS:0]   dax;
  logic signed [COORD_BITS:0]   day;
  logic signed [COORD_BITS:0]   dbx;
  logic signed [COORD_BITS:0]   dby;
  logic signed [COORD_BITS:0]   ex;
  logic signed [COORD_BITS:0]   ey;
  logic signed [PW-1:0]         p_den0;
  logic signed [PW-1:0]         p_den1;
  logic signed [PW-1:0]         p_na0;
  logic signed [PW-1:0]         p_na1;
  logic signed [PW-1:0]         p_nb0;
  logic signed [PW-1:0]         p_nb1;

  assign busy = 1'b0;

  sit_front #(.CB(COORD_BITS)) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (start & ~busy),
    .ax0      (seg_a_start_x),
    .ay0      (seg_a_start_y),
    .ax1      (seg_a_end_x),
    .ay1      (seg_a_end_y),
    .bx0      (seg_b_start_x),
    .by0      (seg_b_start_y),
    .bx1      (seg_b_end_x),
    .by1      (seg_b_end_y),
    .tag      (tag_f),
    .dax      (dax),
    .day      (day),
    .dbx      (dbx),
    .dby      (dby),
    .ex       (ex),
    .ey       (ey)
  );

  sit_mult #(.CB(COORD_BITS)) u_mult (
    .clk    (clk),
    .rst    (rst),
    .tag_in (tag_f),
    .dax    (dax),
    .day    (day),
    .dbx    (dbx),
    .dby    (dby),
    .ex     (ex),
    .ey     (ey),
    .tag    (tag_m),
    .p_den0 (p_den0),
    .p_den1 (p_den1),
    .p_na0  (p_na0),
    .p_na1  (p_na1),
    .p_nb0  (p_nb0),
    .p_nb1  (p_nb1)
  );

  sit_judge #(.CB(COORD_BITS)) u_judge (
    .clk    (clk),
    .rst    (rst),
    .tag_in (tag_m),
    .p_den0 (p_den0),
    .p_den1 (p_den1),
    .p_na0  (p_na0),
    .p_na1  (p_na1),
    .p_nb0  (p_nb0),
    .p_nb1  (p_nb1),
    .done   (done),
    .hit    (hit)
  );

endmodule

// File: tb/sv/segment_hit_checker.sv
// Result checker for segment_intersection_test_unit: predicts hit for every
// pair taken on the start/busy handshake and compares it with each done beat.
// Depends on sit_pkg only; instantiated beside the block by the testbench top.
`timescale 1ns / 1ps

module segment_hit_checker import sit_pkg::*; #(
  parameter int COORD_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic                         busy,
  input  logic signed [COORD_BITS-1:0] seg_a_start_x,
  input  logic signed [COORD_BITS-1:0] seg_a_start_y,
  input  logic signed [COORD_BITS-1:0] seg_a_end_x,
  input  logic signed [COORD_BITS-1:0] seg_a_end_y,
  input  logic signed [COORD_BITS-1:0] seg_b_start_x,
  input  logic signed [COORD_BITS-1:0] seg_b_start_y,
  input  logic signed [COORD_BITS-1:0] seg_b_end_x,
  input  logic signed [COORD_BITS-1:0] seg_b_end_y,
  input  logic                         done,
  input  logic                         hit,
  output int                           errors,
  output int                           outstanding,
  output int                           checked,
  output int                           hits_seen
);

  localparam int PRINT_CAP = 30;

  typedef struct {
    bit          hit;
    int unsigned pair_no;
  } hit_expectation_t;

  hit_expectation_t expected_hits[$];
  hit_expectation_t oldest;
  int unsigned      pairs_taken = 0;
  int               n_errors    = 0;
  int               n_checked   = 0;
  int               n_hits      = 0;

  task automatic report_mismatch(input string msg);
    n_errors++;
    if (n_errors <= PRINT_CAP) $display("MISMATCH at %0t ns: %s", $time, msg);
  endtask

  // n/d within the closed range 0..1, d nonzero
  function automatic bit in_unit_range(longint n, longint d);
    if (d > 0) return n >= 0 && n <= d;
    return n <= 0 && n >= d;
  endfunction

  // both of p, q strictly above or strictly below both of r, s
  function automatic bit strictly_apart(longint p, longint q, longint r, longint s);
    return (p > r && p > s && q > r && q > s) || (p < r && p < s && q < r && q < s);
  endfunction

  function automatic bit segments_meet(longint ax0, longint ay0, longint ax1, longint ay1,
                                       longint bx0, longint by0, longint bx1, longint by1);
    longint dax, day, dbx, dby, ox, oy, denom, num_a, num_b;
    bit     meets;
    meets = FALSE;
    if (!strictly_apart(ax0, ax1, bx0, bx1) && !strictly_apart(ay0, ay1, by0, by1)) begin
      dax   = ax1 - ax0;
      day   = ay1 - ay0;
      dbx   = bx1 - bx0;
      dby   = by1 - by0;
      denom = dbx * day - dax * dby;
      // zero cross product: parallel, collinear or a point, never a hit
      if (denom != 0) begin
        ox    = bx0 - ax0;
        oy    = by0 - ay0;
        num_a = dbx * oy - dby * ox;
        num_b = dax * oy - day * ox;
        meets = in_unit_range(num_a, denom) && in_unit_range(num_b, denom);
      end
    end
    return meets;
  endfunction

  always @(posedge clk) begin
    if (!rst) begin
      // retire the beat first so a pair taken on this edge cannot answer it
      if (done !== 1'b0 && done !== 1'b1) begin
        report_mismatch("done is not a known level");
      end else if (done) begin
        if (expected_hits.size() == 0) begin
          report_mismatch("result beat with no pair outstanding");
        end else begin
          oldest = expected_hits.pop_front();
          if (hit !== oldest.hit)
            report_mismatch($sformatf("pair %0d: hit is %b, expected %b",
                                      oldest.pair_no, hit, oldest.hit));
          n_checked++;
          if (oldest.hit) n_hits++;
        end
      end
      if (start && !busy) begin
        expected_hits.push_back('{
          hit: segments_meet(longint'(seg_a_start_x), longint'(seg_a_start_y),
                             longint'(seg_a_end_x),   longint'(seg_a_end_y),
                             longint'(seg_b_start_x), longint'(seg_b_start_y),
                             longint'(seg_b_end_x),   longint'(seg_b_end_y)),
          pair_no: pairs_taken});
        pairs_taken++;
      end
    end
    errors      <= n_errors;
    outstanding <= expected_hits.size();
    checked     <= n_checked;
    hits_seen   <= n_hits;
  end

endmodule

// File: tb/sv/tb_segment_intersection_test_unit.sv
// Testbench top for segment_intersection_test_unit: clock, reset, directed and
// random segment pairs with idle bursts, and the verdict.
// Depends on sit_pkg, the block itself and segment_hit_checker.
`timescale 1ns / 1ps

module tb_segment_intersection_test_unit;
  import sit_pkg::*;

  localparam int COORD_BITS  = 16;
  localparam int N_RANDOM    = 1800;
  localparam int CALM_TAIL   = 200;
  localparam int DRAIN_WAIT  = 8;
  localparam int CYCLE_LIMIT = 200000;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    coord_t ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
  } seg_pair_t;

  localparam coord_t CMIN = {1'b1, {(COORD_BITS-1){1'b0}}};
  localparam coord_t CMAX = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam int     IMIN = int'(CMIN);
  localparam int     IMAX = int'(CMAX);

  logic   clk = 1'b0;
  logic   rst = 1'b1;
  logic   start = 1'b0;
  coord_t seg_a_start_x = '0, seg_a_start_y = '0, seg_a_end_x = '0, seg_a_end_y = '0;
  coord_t seg_b_start_x = '0, seg_b_start_y = '0, seg_b_end_x = '0, seg_b_end_y = '0;
  logic   busy, done, hit;

  int errors, outstanding, checked, hits_seen;
  int pairs_sent = 0;
  int cycles     = 0;

  segment_intersection_test_unit #(.COORD_BITS(COORD_BITS)) u_top (
    .clk, .rst, .start, .busy,
    .seg_a_start_x, .seg_a_start_y, .seg_a_end_x, .seg_a_end_y,
    .seg_b_start_x, .seg_b_start_y, .seg_b_end_x, .seg_b_end_y,
    .done, .hit
  );

  segment_hit_checker #(.COORD_BITS(COORD_BITS)) u_checker (
    .clk, .rst, .start, .busy,
    .seg_a_start_x, .seg_a_start_y, .seg_a_end_x, .seg_a_end_y,
    .seg_b_start_x, .seg_b_start_y, .seg_b_end_x, .seg_b_end_y,
    .done, .hit,
    .errors, .outstanding, .checked, .hits_seen
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding", cycles, outstanding);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Hold the pair on the ports with start high until the handshake edge.
  task automatic send_pair(input seg_pair_t p);
    seg_a_start_x <= p.ax0;
    seg_a_start_y <= p.ay0;
    seg_a_end_x   <= p.ax1;
    seg_a_end_y   <= p.ay1;
    seg_b_start_x <= p.bx0;
    seg_b_start_y <= p.by0;
    seg_b_end_x   <= p.bx1;
    seg_b_end_y   <= p.by1;
    start         <= 1'b1;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    pairs_sent++;
  endtask

  // Drop start and put noise on the coordinates, which must be ignored.
  task automatic idle_burst(input int n);
    start         <= 1'b0;
    seg_a_start_x <= coord_t'($urandom());
    seg_a_start_y <= coord_t'($urandom());
    seg_a_end_x   <= coord_t'($urandom());
    seg_a_end_y   <= coord_t'($urandom());
    seg_b_start_x <= coord_t'($urandom());
    seg_b_start_y <= coord_t'($urandom());
    seg_b_end_x   <= coord_t'($urandom());
    seg_b_end_y   <= coord_t'($urandom());
    repeat (n) @(posedge clk);
  endtask

  // Hold start low until every answer in flight has been checked.
  task automatic drain;
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  function automatic coord_t near_origin(input int span);
    return coord_t'(int'($urandom_range(2 * span, 0)) - span);
  endfunction

  function automatic coord_t corner_value();
    case ($urandom_range(6, 0))
      0:       return CMIN;
      1:       return CMIN + coord_t'(1);
      2:       return coord_t'(-1);
      3:       return coord_t'(0);
      4:       return coord_t'(1);
      5:       return CMAX - coord_t'(1);
      default: return CMAX;
    endcase
  endfunction

  function automatic seg_pair_t mk_pair(input int ax0, input int ay0,
                                        input int ax1, input int ay1,
                                        input int bx0, input int by0,
                                        input int bx1, input int by1);
    return '{coord_t'(ax0), coord_t'(ay0), coord_t'(ax1), coord_t'(ay1),
             coord_t'(bx0), coord_t'(by0), coord_t'(bx1), coord_t'(by1)};
  endfunction

  seg_pair_t directed_pairs[$];
  seg_pair_t p;
  coord_t    cx, cy, d1x, d1y, d2x, d2y, sx, sy;
  int        gap_pct;

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // extremes, crossings, endpoint contact, parallel, collinear, points, box rejects
    directed_pairs.push_back(mk_pair(IMIN, IMIN, IMIN, IMIN, IMIN, IMIN, IMIN, IMIN));
    directed_pairs.push_back(mk_pair(IMAX, IMAX, IMAX, IMAX, IMAX, IMAX, IMAX, IMAX));
    directed_pairs.push_back(mk_pair(IMIN, IMIN, IMAX, IMAX, IMIN, IMAX, IMAX, IMIN));
    directed_pairs.push_back(mk_pair(-10, 0, 10, 0, 0, -10, 0, 10));
    directed_pairs.push_back(mk_pair(0, 0, 10, 0, 10, 0, 10, 10));
    directed_pairs.push_back(mk_pair(0, 0, 10, 0, 5, 0, 5, 7));
    directed_pairs.push_back(mk_pair(0, 0, 10, 0, 5, 1, 5, 7));
    directed_pairs.push_back(mk_pair(0, 0, 10, 0, 5, 0, 15, 0));
    directed_pairs.push_back(mk_pair(0, 0, 10, 10, 0, 1, 10, 11));
    directed_pairs.push_back(mk_pair(3, 3, 3, 3, 0, 0, 6, 6));
    directed_pairs.push_back(mk_pair(0, 0, 1, 5, 5, 0, 6, 5));
    directed_pairs.push_back(mk_pair(0, 0, 5, 1, 0, 5, 5, 6));
    directed_pairs.push_back(mk_pair(0, 0, 10, 10, 0, 10, 4, 7));
    directed_pairs.push_back(mk_pair(0, 0, 8, 3, 8, 3, 0, 0));
    directed_pairs.push_back(mk_pair(IMIN, IMIN, IMAX, IMIN, IMAX, IMIN, IMAX, IMAX));
    directed_pairs.push_back(mk_pair(10, 0, 0, 10, 10, 10, 0, 0));
    directed_pairs.push_back(mk_pair(-1, -1, 1, 1, -1, 1, 1, -1));
    directed_pairs.push_back(mk_pair(IMIN, 0, IMAX, 0, IMAX, IMIN, IMAX, IMAX));
    directed_pairs.push_back(mk_pair(0, 0, 5, 0, 5, 1, 5, 5));
    directed_pairs.push_back(mk_pair(IMAX, IMIN, IMIN, IMAX, IMIN, IMIN, IMAX, IMAX));
    foreach (directed_pairs[k]) send_pair(directed_pairs[k]);

    gap_pct = 0;
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i % 100 == 0) begin
        case ($urandom_range(3, 0))
          0:       gap_pct = 0;
          1:       gap_pct = 10;
          2:       gap_pct = 25;
          default: gap_pct = 50;
        endcase
      end
      if (i >= N_RANDOM - CALM_TAIL) gap_pct = 0;
      if (i == N_RANDOM / 2) drain();

      case ($urandom_range(9, 0))
        0, 1: begin
          p = seg_pair_t'({$urandom(), $urandom(), $urandom(), $urandom()});
        end
        2, 3, 4: begin
          p = '{near_origin(8), near_origin(8), near_origin(8), near_origin(8),
                near_origin(8), near_origin(8), near_origin(8), near_origin(8)};
        end
        5: begin
          // shared endpoint, in either order on each segment
          p = '{near_origin(2000), near_origin(2000), near_origin(2000), near_origin(2000),
                coord_t'(0), coord_t'(0), near_origin(2000), near_origin(2000)};
          if ($urandom_range(1, 0)) begin
            p.bx0 = p.ax1; p.by0 = p.ay1;
          end else begin
            p.bx0 = p.ax0; p.by0 = p.ay0;
          end
          if ($urandom_range(1, 0)) begin
            {p.bx0, p.by0, p.bx1, p.by1} = {p.bx1, p.by1, p.bx0, p.by0};
          end
        end
        6: begin
          // parallel copy, shifted along or off the line
          d1x = near_origin(1000);
          d1y = near_origin(1000);
          sx  = $urandom_range(1, 0) ? d1x : near_origin(50);
          sy  = $urandom_range(1, 0) ? d1y : near_origin(50);
          cx  = near_origin(10000);
          cy  = near_origin(10000);
          p   = '{cx, cy, cx + d1x, cy + d1y, cx + sx, cy + sy, cx + sx + d1x, cy + sy + d1y};
        end
        7: begin
          // built around a centre: a crossing, or a T touching the centre
          cx  = near_origin(16000);
          cy  = near_origin(16000);
          d1x = near_origin(8000);
          d1y = near_origin(8000);
          d2x = near_origin(8000);
          d2y = near_origin(8000);
          p   = '{cx - d1x, cy - d1y, cx + d1x, cy + d1y, cx - d2x, cy - d2y, cx + d2x, cy + d2y};
          if ($urandom_range(1, 0)) begin
            p.bx0 = cx; p.by0 = cy;
          end
        end
        8: begin
          p = '{corner_value(), corner_value(), corner_value(), corner_value(),
                corner_value(), corner_value(), corner_value(), corner_value()};
        end
        default: begin
          p = '{near_origin(300), near_origin(300), coord_t'(0), coord_t'(0),
                near_origin(300), near_origin(300), near_origin(300), near_origin(300)};
          p.ax1 = p.ax0;
          p.ay1 = p.ay0;
          if ($urandom_range(1, 0)) begin
            {p.ax0, p.ay0, p.ax1, p.ay1, p.bx0, p.by0, p.bx1, p.by1} =
              {p.bx0, p.by0, p.bx1, p.by1, p.ax0, p.ay0, p.ax1, p.ay1};
          end
        end
      endcase

      send_pair(p);
      if (gap_pct != 0 && $urandom_range(99, 0) < gap_pct) idle_burst($urandom_range(7, 1));
    end

    drain();
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Sent %0d segment pairs (directed extremes and special cases, then random mixes).",
             pairs_sent);
    $display("Checked %0d answers, %0d of them hits, %0d mismatches.", checked, hits_seen, errors);
    if (errors == 0 && checked == pairs_sent) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// File: files.f
hw/rtl/sit_pkg.sv
hw/rtl/sit_front.sv
hw/rtl/sit_mult.sv
hw/rtl/sit_judge.sv
hw/rtl/segment_intersection_test_unit.sv
tb/sv/segment_hit_checker.sv
tb/sv/tb_segment_intersection_test_unit.sv
